@@ hdl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token kinds and scan modes for the script token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int PosBits  = 24;
  localparam int FieldBits = 24;
  localparam int KindBits = 6;

  localparam logic [KindBits-1:0] K_DOT        = 6'd6;
  localparam logic [KindBits-1:0] K_MINUS      = 6'd7;
  localparam logic [KindBits-1:0] K_BANG       = 6'd11;
  localparam logic [KindBits-1:0] K_EQUAL      = 6'd13;
  localparam logic [KindBits-1:0] K_LESS       = 6'd15;
  localparam logic [KindBits-1:0] K_GREATER    = 6'd17;
  localparam logic [KindBits-1:0] K_IDENT      = 6'd19;
  localparam logic [KindBits-1:0] K_STRING     = 6'd20;
  localparam logic [KindBits-1:0] K_NUMBER     = 6'd21;
  localparam logic [KindBits-1:0] K_EOF        = 6'd38;
  localparam logic [KindBits-1:0] K_ERR_CHAR   = 6'd39;
  localparam logic [KindBits-1:0] K_ERR_STRING = 6'd40;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING, M_MINUS, M_COMMENT,
    M_BANG, M_EQUAL, M_LESS, M_GREATER
  } mode_t;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] length;
    logic [FieldBits-1:0] line;
  } token_t;

  // Up to three tokens caused by one input byte.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } group_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
           b == 8'h5f || b == 8'h24;
  endfunction

  // Keyword lookup on up to six packed bytes plus the identifier length.
  function automatic logic [KindBits-1:0] ident_kind(input logic [47:0] p,
                                                     input logic [2:0] n);
    logic [KindBits-1:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if (p == 48'h6966) k = 6'd28;
        if (p == 48'h6f72) k = 6'd30;
      end
      3'd3: begin
        if (p == 48'h616e64) k = 6'd22;
        if (p == 48'h666f72) k = 6'd26;
        if (p == 48'h66756e) k = 6'd27;
        if (p == 48'h766172) k = 6'd36;
      end
      3'd4: begin
        if (p == 48'h656c7365) k = 6'd24;
        if (p == 48'h6e6f6e65) k = 6'd29;
        if (p == 48'h74686973) k = 6'd34;
        if (p == 48'h74727565) k = 6'd35;
      end
      3'd5: begin
        if (p == 48'h636c617373) k = 6'd23;
        if (p == 48'h66616c7365) k = 6'd25;
        if (p == 48'h7072696e74) k = 6'd31;
        if (p == 48'h7375706572) k = 6'd33;
        if (p == 48'h7768696c65) k = 6'd37;
      end
      3'd6: begin
        if (p == 48'h72657475726e) k = 6'd32;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/script_token_scanner.sv @@
// ----------------------------------------------------------------------------
// script_token_scanner
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one source byte or end-of-input request
// per transfer; a zero byte also ends input. Output channel
// (out_valid/out_ready): one token per transfer with kind, start, length,
// line, and last_of_run marking the final token caused by one input.
// Throughput: one input byte per cycle while the token queue has room, set by
// the scanner state update in the front part. A byte yields 0 to 3 tokens,
// pushed into an 8-entry token queue that drains one token per cycle while
// out_ready is high. A token caused by a byte is written into the queue when
// that byte is taken. Tokens ended by the following byte appear after it.
// When the receiver stalls, the queue fills and in_ready drops once fewer
// than three slots remain; nothing is lost.
// Reset (rst, synchronous): scanner idle, offsets zero, line one, queue empty.
// End of input flushes the pending token, emits EOF and returns to the
// reset state.
// ----------------------------------------------------------------------------
module script_token_scanner import sts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [7:0]           byte_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KindBits-1:0]  token_kind,
  output logic [FieldBits-1:0] token_start,
  output logic [FieldBits-1:0] token_length,
  output logic [FieldBits-1:0] token_line,
  output logic                 last_of_run
);

  logic   grp_valid, grp_ready;
  group_t grp;

  sts_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .byte_value,
    .grp_valid, .grp_ready, .grp
  );

  sts_back u_back (
    .clk, .rst, .grp_valid, .grp_ready, .grp,
    .out_valid, .out_ready, .token_kind, .token_start, .token_length,
    .token_line, .last_of_run
  );

endmodule

@@ hdl/sts_front.sv @@
// ----------------------------------------------------------------------------
// sts_front
// Scanner state: a byte per cycle if grp_ready; forms the token group it ends.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type,
  input  logic [7:0]   byte_value,
  output logic         grp_valid,
  input  logic         grp_ready,
  output group_t       grp
);

  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [FieldBits-1:0] LineMax = '1;

  mode_t                scan_mode, scan_mode_next;
  logic [PosBits-1:0]   token_begin, token_begin_next;
  logic [PosBits-1:0]   byte_position, byte_position_next;
  logic [FieldBits-1:0] line_count, line_count_next;
  logic [47:0]          keyword_prefix, keyword_prefix_next;
  // identifier length, saturated at 7 (only up to 6 matters for keywords)
  logic [2:0]           id_len, id_len_next;

  logic         fire;
  logic         done;
  logic [7:0]   b;
  group_t       g;
  logic [PosBits-1:0] len, pos_inc;
  logic         absorbed;
  logic [KindBits-1:0] one;

  assign in_ready = grp_ready;
  assign fire = in_valid && in_ready;
  assign b    = byte_value;
  assign done = req_type || (byte_value == 8'd0);
  assign len  = byte_position - token_begin;
  assign pos_inc = (byte_position == PosMax) ? PosMax : byte_position + 1'b1;

  always_comb begin
    one = K_BANG;
    case (scan_mode)
      M_EQUAL:   one = K_EQUAL;
      M_LESS:    one = K_LESS;
      M_GREATER: one = K_GREATER;
      default:   one = K_BANG;
    endcase
  end

  function automatic token_t mk(input logic [KindBits-1:0] k,
                                input logic [PosBits-1:0] s,
                                input logic [PosBits-1:0] l,
                                input logic [FieldBits-1:0] ln);
    token_t t;
    t.kind   = k;
    t.start  = FieldBits'(s);
    t.length = FieldBits'(l);
    t.line   = ln;
    return t;
  endfunction

  // Append a token to the group being built.
  function automatic group_t push(input group_t gi, input token_t t);
    group_t go;
    go = gi;
    case (gi.count)
      2'd0:    go.t0 = t;
      2'd1:    go.t1 = t;
      default: go.t2 = t;
    endcase
    go.count = gi.count + 2'd1;
    return go;
  endfunction

  always_comb begin
    g = '0;
    absorbed = 1'b0;
    scan_mode_next      = scan_mode;
    token_begin_next    = token_begin;
    byte_position_next  = byte_position;
    line_count_next     = line_count;
    keyword_prefix_next = keyword_prefix;
    id_len_next         = id_len;

    // finish or extend the pending token
    case (scan_mode)
      M_IDENT: begin
        if (!done && (is_alpha(b) || is_digit(b))) begin
          absorbed = 1'b1;
          if (id_len < 3'd6) keyword_prefix_next = {keyword_prefix[39:0], b};
          if (id_len != 3'd7) id_len_next = id_len + 3'd1;
        end else begin
          g = push(g, mk(ident_kind(keyword_prefix, id_len), token_begin, len,
                         line_count));
        end
      end
      M_INT: begin
        if (!done && is_digit(b)) absorbed = 1'b1;
        else if (!done && b == 8'h2e) begin
          absorbed = 1'b1;
          scan_mode_next = M_DOT;
        end else g = push(g, mk(K_NUMBER, token_begin, len, line_count));
      end
      M_DOT: begin
        if (!done && is_digit(b)) begin
          absorbed = 1'b1;
          scan_mode_next = M_FRAC;
        end else begin
          g = push(g, mk(K_NUMBER, token_begin,
                         (len != '0) ? len - 1'b1 : '0, line_count));
          g = push(g, mk(K_DOT, (byte_position != '0) ? byte_position - 1'b1 : '0,
                         PosBits'(1), line_count));
        end
      end
      M_FRAC: begin
        if (!done && is_digit(b)) absorbed = 1'b1;
        else g = push(g, mk(K_NUMBER, token_begin, len, line_count));
      end
      M_STRING: begin
        if (done) begin
          g = push(g, mk(K_ERR_STRING, token_begin, len, line_count));
        end else if (b == 8'h27) begin
          absorbed = 1'b1;
          g = push(g, mk(K_STRING, token_begin, pos_inc - token_begin, line_count));
          scan_mode_next = M_IDLE;
        end else begin
          absorbed = 1'b1;
          if (b == 8'h0a && line_count != LineMax) line_count_next = line_count + 1'b1;
        end
      end
      M_MINUS: begin
        if (!done && b == 8'h2d) begin
          absorbed = 1'b1;
          scan_mode_next = M_COMMENT;
        end else g = push(g, mk(K_MINUS, token_begin, len, line_count));
      end
      M_COMMENT: begin
        if (!done && b != 8'h0a) absorbed = 1'b1;
      end
      M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
        if (!done && b == 8'h3d) begin
          absorbed = 1'b1;
          g = push(g, mk(one + 6'd1, token_begin, pos_inc - token_begin, line_count));
          scan_mode_next = M_IDLE;
        end else g = push(g, mk(one, token_begin, len, line_count));
      end
      default: ;
    endcase
    if (!absorbed) scan_mode_next = M_IDLE;

    if (done) begin
      g = push(g, mk(K_EOF, byte_position, '0, line_count_next));
      scan_mode_next      = M_IDLE;
      token_begin_next    = '0;
      byte_position_next  = '0;
      line_count_next     = FieldBits'(1);
      keyword_prefix_next = '0;
      id_len_next         = '0;
    end else begin
      if (!absorbed) begin
        case (b)
          8'h20, 8'h0d, 8'h09: ;
          8'h0a: if (line_count != LineMax) line_count_next = line_count + 1'b1;
          8'h2d: begin scan_mode_next = M_MINUS;   token_begin_next = byte_position; end
          8'h27: begin scan_mode_next = M_STRING;  token_begin_next = byte_position; end
          8'h21: begin scan_mode_next = M_BANG;    token_begin_next = byte_position; end
          8'h3d: begin scan_mode_next = M_EQUAL;   token_begin_next = byte_position; end
          8'h3c: begin scan_mode_next = M_LESS;    token_begin_next = byte_position; end
          8'h3e: begin scan_mode_next = M_GREATER; token_begin_next = byte_position; end
          8'h28: g = push(g, mk(6'd0, byte_position, PosBits'(1), line_count));
          8'h29: g = push(g, mk(6'd1, byte_position, PosBits'(1), line_count));
          8'h7b: g = push(g, mk(6'd2, byte_position, PosBits'(1), line_count));
          8'h7d: g = push(g, mk(6'd3, byte_position, PosBits'(1), line_count));
          8'h3b: g = push(g, mk(6'd4, byte_position, PosBits'(1), line_count));
          8'h2c: g = push(g, mk(6'd5, byte_position, PosBits'(1), line_count));
          8'h2e: g = push(g, mk(K_DOT, byte_position, PosBits'(1), line_count));
          8'h2b: g = push(g, mk(6'd8, byte_position, PosBits'(1), line_count));
          8'h2f: g = push(g, mk(6'd9, byte_position, PosBits'(1), line_count));
          8'h2a: g = push(g, mk(6'd10, byte_position, PosBits'(1), line_count));
          default: begin
            if (is_alpha(b)) begin
              scan_mode_next      = M_IDENT;
              token_begin_next    = byte_position;
              keyword_prefix_next = {40'd0, b};
              id_len_next         = 3'd1;
            end else if (is_digit(b)) begin
              scan_mode_next   = M_INT;
              token_begin_next = byte_position;
            end else begin
              g = push(g, mk(K_ERR_CHAR, byte_position, PosBits'(1), line_count));
            end
          end
        endcase
      end
      byte_position_next = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= M_IDLE;
      token_begin    <= '0;
      byte_position  <= '0;
      line_count     <= FieldBits'(1);
      keyword_prefix <= '0;
      id_len         <= '0;
    end else if (fire) begin
      scan_mode      <= scan_mode_next;
      token_begin    <= token_begin_next;
      byte_position  <= byte_position_next;
      line_count     <= line_count_next;
      keyword_prefix <= keyword_prefix_next;
      id_len         <= id_len_next;
    end
  end

  // groups with no tokens are dropped here
  assign grp_valid = fire && (g.count != 2'd0);
  assign grp       = g;

`ifndef SYNTHESIS
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0) else $error("line count reached zero");
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    fire && done |=> byte_position == '0 && scan_mode == M_IDLE)
    else $error("end of input did not reset scanner");
  a_grp_count: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> g.count != 2'd3 || scan_mode == M_DOT)
    else $error("three tokens outside number-dot case");
`endif

endmodule

@@ hdl/sts_back.sv @@
// ----------------------------------------------------------------------------
// sts_back
// Token queue/serializer: stores token groups, one token a cycle on out_ready.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 grp_valid,
  output logic                 grp_ready,
  input  group_t               grp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KindBits-1:0]  token_kind,
  output logic [FieldBits-1:0] token_start,
  output logic [FieldBits-1:0] token_length,
  output logic [FieldBits-1:0] token_line,
  output logic                 last_of_run
);

  // token FIFO, 8 entries; front needs room for three tokens
  localparam int Depth = 8;
  localparam int AW = $clog2(Depth);

  token_t       mem_tok [Depth];
  logic         mem_last [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;
  logic         pop, push_en;
  logic [1:0]   n_in;
  logic [AW:0]  room;

  assign room      = (AW+1)'(Depth) - fill;
  assign grp_ready = fill <= (AW+1)'(Depth - 3);
  assign push_en   = grp_valid && grp_ready;
  assign n_in      = push_en ? grp.count : 2'd0;
  assign out_valid = fill != '0;
  assign pop       = out_valid && out_ready;

  assign token_kind   = mem_tok[rd_ptr].kind;
  assign token_start  = mem_tok[rd_ptr].start;
  assign token_length = mem_tok[rd_ptr].length;
  assign token_line   = mem_tok[rd_ptr].line;
  assign last_of_run  = mem_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_tok[wr_ptr]           <= grp.t0;
      mem_last[wr_ptr]          <= grp.count == 2'd1;
      if (grp.count >= 2'd2) begin
        mem_tok[wr_ptr + AW'(1)]  <= grp.t1;
        mem_last[wr_ptr + AW'(1)] <= grp.count == 2'd2;
      end
      if (grp.count == 2'd3) begin
        mem_tok[wr_ptr + AW'(2)]  <= grp.t2;
        mem_last[wr_ptr + AW'(2)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_in);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      fill <= fill + (AW+1)'(n_in) - (AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(Depth)) else $error("token queue overflow");
  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    AW'(wr_ptr - rd_ptr) == AW'(fill)) else $error("queue pointers out of step");
  a_room: assert property (@(posedge clk) disable iff (rst)
    room <= (AW+1)'(Depth)) else $error("queue room out of range");
`endif

endmodule
